// File: rtl/slfr_pkg.sv
// shared constants and types of the sync/length frame receiver
package slfr_pkg;

    localparam logic [7:0] SYNC_A = 8'hEA;
    localparam logic [7:0] SYNC_B = 8'h55;

    localparam logic [7:0] TYPE_REPLY = 8'd0;
    localparam logic [7:0] TYPE_NOTE  = 8'd1;
    localparam logic [7:0] TYPE_IMAGE = 8'd2;

    localparam logic [7:0] FACE_FLAG   = 8'h80;
    localparam logic [7:0] FACE_LEFT   = 8'h81;
    localparam logic [7:0] FACE_CENTRE = 8'h82;
    localparam logic [7:0] FACE_RIGHT  = 8'h84;

    localparam logic [15:0] USER_ID_LENGTH = 16'd6;

    localparam logic [2:0] KIND_REPLY       = 3'd0;
    localparam logic [2:0] KIND_NOTE_READY  = 3'd1;
    localparam logic [2:0] KIND_NOTE_FACE   = 3'd2;
    localparam logic [2:0] KIND_IMAGE       = 3'd3;
    localparam logic [2:0] KIND_TOO_SHORT   = 3'd4;
    localparam logic [2:0] KIND_BAD_LENGTH  = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN     = 3'd6;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         reply_msg_id;
        logic [7:0]         reply_code;
        logic [7:0]         reply_first_data;
        logic signed [31:0] user_id;
        logic [7:0]         note_id;
        logic               face_left;
        logic               face_center;
        logic               face_right;
        logic [15:0]        data_length;
    } slfr_result_t;

endpackage

// File: rtl/slfr_in_if.sv
// byte input channel
interface slfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/slfr_out_if.sv
// frame result channel
interface slfr_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [7:0]         reply_msg_id;
    logic [7:0]         reply_code;
    logic [7:0]         reply_first_data;
    logic signed [31:0] user_id;
    logic [7:0]         note_id;
    logic               face_left;
    logic               face_center;
    logic               face_right;
    logic [15:0]        data_length;

    modport source (
        output valid, output kind, output reply_msg_id, output reply_code,
        output reply_first_data, output user_id, output note_id,
        output face_left, output face_center, output face_right,
        output data_length, input ready
    );
    modport sink (
        input valid, input kind, input reply_msg_id, input reply_code,
        input reply_first_data, input user_id, input note_id,
        input face_left, input face_center, input face_right,
        input data_length, output ready
    );
endinterface

// File: rtl/slfr_parser.sv
// frame state machine and result classification
module slfr_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    input  logic [7:0]            byte_in,
    output logic                  res_valid,
    output slfr_pkg::slfr_result_t res
);
    import slfr_pkg::*;

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_SYNC  = 3'd1;
    localparam logic [2:0] PH_TYPE  = 3'd2;
    localparam logic [2:0] PH_LENH  = 3'd3;
    localparam logic [2:0] PH_LENL  = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_CHECK = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  mid_reg, mid_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  fd_reg, fd_next;
    logic [31:0] uid_reg, uid_next;
    logic [15:0] len_full;
    logic        last_data;

    assign len_full  = {len_reg[15:8], byte_in};
    assign last_data = (pos_reg == (len_reg - 16'd1));

    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        mid_next   = mid_reg;
        code_next  = code_reg;
        fd_next    = fd_reg;
        uid_next   = uid_reg;
        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (byte_in == SYNC_A)
                        phase_next = PH_SYNC;
                end
                PH_SYNC:
                begin
                    if (byte_in == SYNC_B)
                        phase_next = PH_TYPE;
                    else if (byte_in != SYNC_A)
                        phase_next = PH_HUNT;
                end
                PH_TYPE:
                begin
                    type_next  = byte_in;
                    phase_next = PH_LENH;
                end
                PH_LENH:
                begin
                    len_next   = {byte_in, 8'd0};
                    phase_next = PH_LENL;
                end
                PH_LENL:
                begin
                    len_next   = len_full;
                    pos_next   = 16'd0;
                    mid_next   = 8'd0;
                    code_next  = 8'd0;
                    fd_next    = 8'd0;
                    uid_next   = 32'd0;
                    phase_next = (len_full == 16'd0) ? PH_CHECK : PH_DATA;
                end
                PH_DATA:
                begin
                    if (pos_reg == 16'd0)
                        mid_next = byte_in;
                    if (pos_reg == 16'd1)
                        code_next = byte_in;
                    if (pos_reg == 16'd2)
                        fd_next = byte_in;
                    if (pos_reg >= 16'd2 && pos_reg <= 16'd5)
                        uid_next = {uid_reg[23:0], byte_in};
                    if (last_data)
                        phase_next = PH_CHECK;
                    else
                        pos_next = pos_reg + 16'd1;
                end
                PH_CHECK:
                begin
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            type_reg  <= 8'd0;
            len_reg   <= 16'd0;
            pos_reg   <= 16'd0;
            mid_reg   <= 8'd0;
            code_reg  <= 8'd0;
            fd_reg    <= 8'd0;
            uid_reg   <= 32'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            mid_reg   <= mid_next;
            code_reg  <= code_next;
            fd_reg    <= fd_next;
            uid_reg   <= uid_next;
        end
    end

    assign res_valid = byte_valid && (phase_reg == PH_CHECK);

    // classification of the completed frame
    always_comb
    begin
        res             = '0;
        res.data_length = len_reg;
        if (len_reg == 16'd0)
            res.kind = KIND_TOO_SHORT;
        else if (type_reg == TYPE_REPLY)
        begin
            if (len_reg < 16'd2)
                res.kind = KIND_BAD_LENGTH;
            else
            begin
                res.kind         = KIND_REPLY;
                res.reply_msg_id = mid_reg;
                res.reply_code   = code_reg;
                if (len_reg >= 16'd3)
                    res.reply_first_data = fd_reg;
                if (len_reg == USER_ID_LENGTH)
                    res.user_id = uid_reg;
            end
        end
        else if (type_reg == TYPE_NOTE)
        begin
            if (mid_reg == 8'd0)
                res.kind = KIND_NOTE_READY;
            else
            begin
                res.kind = KIND_NOTE_FACE;
                if ((mid_reg & FACE_FLAG) == FACE_FLAG)
                begin
                    res.face_left   = ((mid_reg & FACE_LEFT) == FACE_LEFT);
                    res.face_center = ((mid_reg & FACE_CENTRE) == FACE_CENTRE);
                    res.face_right  = ((mid_reg & FACE_RIGHT) == FACE_RIGHT);
                end
                else
                    res.note_id = mid_reg;
            end
        end
        else if (type_reg == TYPE_IMAGE)
            res.kind = KIND_IMAGE;
        else
            res.kind = KIND_UNKNOWN;
    end

    // position never runs past the length while data is read
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (pos_reg < len_reg))
        else $error("data position beyond frame length");

    // an empty frame goes straight to the check byte
    a_empty_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && phase_reg == PH_LENL && len_full == 16'd0)
        |=> (phase_reg == PH_CHECK))
        else $error("zero length frame did not skip data");

    // after a result the parser is hunting again
    a_check_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (phase_reg == PH_HUNT))
        else $error("parser did not return to hunting after a frame");

endmodule

// File: rtl/sync_length_frame_receiver_top.sv
// top level of the sync/length frame receiver
//
//  channel  dir  payload                                  handshake
//  rx       in   rx_byte[7:0]                             valid/ready
//  result   out  kind, reply fields, user_id, note/face,  valid/ready
//                data_length
//
// one received byte is taken per cycle while rx.ready is high; the parser state
// advances at the same edge, and the check byte's transaction loads the result
// register at that edge, so the result is offered from the next cycle on
// rx.ready is high whenever the result register is empty or being taken; while a
// result waits and is not taken every byte stalls
// rst_n clears the parser state and the result valid flag asynchronously;
// the parser comes out of reset hunting for the first sync byte
// only the check byte of a frame writes the result register
module sync_length_frame_receiver_top (
    input  logic        clk,
    input  logic        rst_n,
    slfr_in_if.sink     rx,
    slfr_out_if.source  result
);
    import slfr_pkg::*;

    logic         accept;
    logic         res_valid;
    slfr_result_t res;

    // output register
    logic         result_valid_reg, result_valid_next;
    slfr_result_t result_reg;

    // free when empty or when the waiting result goes this cycle
    assign rx.ready = !result_valid_reg || result.ready;
    assign accept   = rx.valid && rx.ready;

    slfr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (accept),
        .byte_in    (rx.rx_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (result.ready)
            result_valid_next = 1'b0;
        if (accept && res_valid)
            result_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    // payload loads only with a new result
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
            result_reg <= res;
    end

    assign result.valid            = result_valid_reg;
    assign result.kind             = result_reg.kind;
    assign result.reply_msg_id     = result_reg.reply_msg_id;
    assign result.reply_code       = result_reg.reply_code;
    assign result.reply_first_data = result_reg.reply_first_data;
    assign result.user_id          = result_reg.user_id;
    assign result.note_id          = result_reg.note_id;
    assign result.face_left        = result_reg.face_left;
    assign result.face_center      = result_reg.face_center;
    assign result.face_right       = result_reg.face_right;
    assign result.data_length      = result_reg.data_length;

    // a new result only follows an accepted byte
    a_result_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(rx.valid && rx.ready))
        else $error("result appeared without an accepted byte");

    // face flags belong to note face transactions only
    a_face_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.face_left || result.face_center || result.face_right))
        |-> (result.kind == KIND_NOTE_FACE))
        else $error("face flags on a non face result");

    // reply fields are zero outside replies
    a_reply_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.kind != KIND_REPLY)
        |-> (result.user_id == 32'sd0 && result.reply_msg_id == 8'd0
             && result.reply_code == 8'd0))
        else $error("reply fields set on a non reply result");

endmodule
